### sv/sample_history_min_max_top_macros.svh
// Assertion macros for the sample history min/max RTL (used by the sequencer).
`ifndef SAMPLE_HISTORY_MIN_MAX_TOP_MACROS_SVH
`define SAMPLE_HISTORY_MIN_MAX_TOP_MACROS_SVH

`ifndef SYNTH
// Plain property check on the rising clock edge, held off during reset.
`define SHMM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("shmm assertion failed");
// Implication check: when ante holds, cons must hold in the same cycle.
`define SHMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("shmm implication failed");
// Implication check: when ante holds, cons must hold in the next cycle.
`define SHMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("shmm next-cycle check failed");
`else
`define SHMM_ASSERT(lbl, clk, rst_n, prop)
`define SHMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/shmm_pkg.sv
// Package: sizes, shared types and pointer helper for the sample history block.
package shmm_pkg;

	localparam int DEPTH     = 256;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int SAMPLE_W  = 8;
	localparam int WORD_W    = 2 * SAMPLE_W;
	localparam int CNT_W     = (PTR_W > SAMPLE_W) ? PTR_W : SAMPLE_W;
	localparam int COUNT_MAX = 255;

	// History RAM access from the controller
	typedef struct packed {
		logic                we;
		logic [PTR_W-1:0]    waddr;
		logic [WORD_W-1:0]   wdata;
		logic                re;
		logic [PTR_W-1:0]    raddr;
	} mem_req_t;

	// Controls for the min/max fold unit
	typedef struct packed {
		logic fold;   // read data valid this cycle
		logic first;  // this is the oldest kept entry
		logic emit;   // load the result register
	} fold_ctl_t;

	// Ring pointer advance with wrap at DEPTH
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

### sv/shmm_ifs.sv
// Valid/ready channel interfaces: sample request in, min/max result out.
interface shmm_sample_if;
	import shmm_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] temperature;
	logic [SAMPLE_W-1:0] humidity;

	modport source (output valid, output temperature, output humidity, input ready);
	modport sink   (input valid, input temperature, input humidity, output ready);
endinterface

interface shmm_result_if;
	import shmm_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] temperature_min;
	logic [SAMPLE_W-1:0] temperature_max;
	logic [SAMPLE_W-1:0] humidity_low;
	logic [SAMPLE_W-1:0] humidity_high;
	logic [SAMPLE_W-1:0] sample_count;

	modport source (output valid, output temperature_min, output temperature_max,
		output humidity_low, output humidity_high, output sample_count, input ready);
	modport sink   (input valid, input temperature_min, input temperature_max,
		input humidity_low, input humidity_high, input sample_count, output ready);
endinterface

### sv/shmm_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module shmm_ram #(
	parameter  int DEPTH_P = 256,
	parameter  int WIDTH_P = 16,
	localparam int AW      = $clog2(DEPTH_P)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [WIDTH_P-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [WIDTH_P-1:0] rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered when re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/shmm_fold.sv
// Min/max fold over history entries read back from the RAM, plus result register.
module shmm_fold (
	input  logic                          clk,
	input  shmm_pkg::fold_ctl_t           ctl,
	input  logic [shmm_pkg::WORD_W-1:0]   rd_data,
	output logic [shmm_pkg::SAMPLE_W-1:0] temperature_min,
	output logic [shmm_pkg::SAMPLE_W-1:0] temperature_max,
	output logic [shmm_pkg::SAMPLE_W-1:0] humidity_low,
	output logic [shmm_pkg::SAMPLE_W-1:0] humidity_high,
	output logic [shmm_pkg::SAMPLE_W-1:0] sample_count
);
	import shmm_pkg::*;

	logic [SAMPLE_W-1:0] t_rd, h_rd;
	logic [SAMPLE_W-1:0] t_lo_q, t_hi_q, h_lo_q, h_hi_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] t_min_q, t_max_q, h_min_q, h_max_q, count_q;

	assign t_rd = rd_data[WORD_W-1:SAMPLE_W];
	assign h_rd = rd_data[SAMPLE_W-1:0];

	// running extremes and entry count
	always_ff @(posedge clk) begin
		if (ctl.fold) begin
			if (ctl.first) begin
				t_lo_q <= t_rd;
				t_hi_q <= t_rd;
				h_lo_q <= h_rd;
				h_hi_q <= h_rd;
				cnt_q  <= CNT_W'(1);
			end else begin
				t_lo_q <= (t_rd < t_lo_q) ? t_rd : t_lo_q;
				t_hi_q <= (t_rd > t_hi_q) ? t_rd : t_hi_q;
				h_lo_q <= (h_rd < h_lo_q) ? h_rd : h_lo_q;
				h_hi_q <= (h_rd > h_hi_q) ? h_rd : h_hi_q;
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

	// result register, count saturates at 8 bits
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			t_min_q <= t_lo_q;
			t_max_q <= t_hi_q;
			h_min_q <= h_lo_q;
			h_max_q <= h_hi_q;
			count_q <= (cnt_q > CNT_W'(COUNT_MAX)) ? SAMPLE_W'(COUNT_MAX)
			                                       : cnt_q[SAMPLE_W-1:0];
		end
	end

	assign temperature_min = t_min_q;
	assign temperature_max = t_max_q;
	assign humidity_low    = h_min_q;
	assign humidity_high   = h_max_q;
	assign sample_count    = count_q;

endmodule

### sv/shmm_ctrl.sv
// Sequencer: ring pointers, history write, oldest-to-newest read walk, output handshake.
`include "sample_history_min_max_top_macros.svh"

module shmm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [shmm_pkg::SAMPLE_W-1:0] temperature,
	input  logic [shmm_pkg::SAMPLE_W-1:0] humidity,
	output logic                          out_valid,
	input  logic                          out_ready,
	output shmm_pkg::mem_req_t            mem_req,
	output shmm_pkg::fold_ctl_t           fold_ctl
);
	import shmm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [PTR_W-1:0] wp_q, op_q, rd_q;
	logic [PTR_W-1:0] wp_n, op_n, rd_n;
	logic             first_q, first_s1, rvalid_s1, out_valid_q;
	logic             accept, out_free;

	// next pointers on a new sample; drop the oldest when the ring wraps
	assign wp_n     = ptr_next(wp_q);
	assign op_n     = (op_q == wp_n) ? ptr_next(op_q) : op_q;
	assign rd_n     = ptr_next(rd_q);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// sequencer state and registered controls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			op_q        <= '0;
			rd_q        <= '0;
			first_q     <= 1'b0;
			first_s1    <= 1'b0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= 1'b0;
			first_s1  <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wp_q    <= wp_n;
						op_q    <= op_n;
						rd_q    <= op_n;
						first_q <= 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rvalid_s1 <= 1'b1;
					first_s1  <= first_q;
					first_q   <= 1'b0;
					rd_q      <= rd_n;
					if (rd_n == wp_q) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// last entry folds this cycle
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// RAM requests: write on accept, read during the walk
	always_comb begin
		mem_req.we    = accept;
		mem_req.waddr = wp_q;
		mem_req.wdata = {temperature, humidity};
		mem_req.re    = (state_q == ST_READ);
		mem_req.raddr = rd_q;
	end

	// fold unit controls
	always_comb begin
		fold_ctl.fold  = rvalid_s1;
		fold_ctl.first = first_s1;
		fold_ctl.emit  = (state_q == ST_EMIT) && out_free;
	end

	assign out_valid = out_valid_q;

	`SHMM_ASSERT(a_no_rw_overlap, clk, arst_n, !(mem_req.we && mem_req.re))
	`SHMM_ASSERT_NXT(a_accept_walks, clk, arst_n, accept, state_q == ST_READ && first_q)
	`SHMM_ASSERT_IMP(a_read_kept, clk, arst_n, mem_req.re, mem_req.raddr != wp_q)
	`SHMM_ASSERT_IMP(a_emit_free, clk, arst_n, fold_ctl.emit, !out_valid_q || out_ready)
	`SHMM_ASSERT_IMP(a_first_fold, clk, arst_n, fold_ctl.first, fold_ctl.fold)

endmodule

### sv/sample_history_min_max_top.sv
// Top level: sample history ring with running min/max and kept-sample count.
//
// Usage:
//   sample (sink): one temperature/humidity request, taken when valid && ready.
//   result (source): min/max of each channel over the kept history and the
//   kept count, offered when valid, handed over when valid && ready.
// Timing:
//   A sample is written into the history RAM at acceptance, then the kept
//   entries (N, from 1 to DEPTH-1) are read back oldest to newest, one per
//   cycle through the single RAM read port. Each read word is registered in
//   the RAM and then folded; the result register loads once the output is
//   free, and no new sample is taken until the result is offered.
// Reset:
//   arst_n clears the ring pointers and the sequencer; the history RAM is not
//   cleared, and only entries already written are ever read.
// Backpressure:
//   A finished result waits in the output register; the next sample is still
//   taken and walked, and only the load of its result waits for the receiver.
module sample_history_min_max_top (
	input  logic                 clk,
	input  logic                 arst_n,
	shmm_sample_if.sink          sample,
	shmm_result_if.source        result
);
	import shmm_pkg::*;

	mem_req_t          mem_req;
	fold_ctl_t         fold_ctl;
	logic [WORD_W-1:0] rd_data;

	// sequencer
	shmm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sample.valid),
		.in_ready    (sample.ready),
		.temperature (sample.temperature),
		.humidity    (sample.humidity),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.mem_req     (mem_req),
		.fold_ctl    (fold_ctl)
	);

	// history ring: temperature in the high byte, humidity in the low byte
	shmm_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

	// min/max fold and result register
	shmm_fold u_fold (
		.clk             (clk),
		.ctl             (fold_ctl),
		.rd_data         (rd_data),
		.temperature_min (result.temperature_min),
		.temperature_max (result.temperature_max),
		.humidity_low    (result.humidity_low),
		.humidity_high   (result.humidity_high),
		.sample_count    (result.sample_count)
	);

endmodule
